// ----- rtl/mpn_pkg.sv -----
// Package for the multichannel mix store with peak normalization.
// Holds beat structs, command and status codes, state encoding and constants.
// No dependencies.
`timescale 1ns / 1ps

package mpn_pkg;

	localparam int MAX_FRAMES_DEF   = 256;
	localparam int MAX_CHANNELS_DEF = 8;

	localparam int ACC_W     = 40;
	localparam int SCALE_W   = 18;
	localparam int QUO_BITS  = 17;
	localparam int PROD_W    = 33;

	localparam logic [SCALE_W-1:0] SCALE_UNITY = SCALE_W'(131072);
	localparam logic [ACC_W-1:0]   ONE_Q27     = ACC_W'(134217728);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER_CHANNELS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FRAMES    = 1'b1;

	localparam logic [3:0] MASTER_CHANNELS_RST = 4'd2;
	localparam logic [8:0] BLOCK_FRAMES_RST    = 9'd256;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ACC   = 2'd1,
		CMD_FIN   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_NOCH  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [7:0]         frame_index;
		logic [2:0]         channel;
		logic signed [15:0] sample;
		logic [15:0]        gain;
		logic               mono_source;
	} cmd_beat_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               normalized;
		status_t            status;
	} rsp_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_SCAN,
		ST_SCAN_END,
		ST_SCAN_DEC,
		ST_DIV,
		ST_RD_MEM,
		ST_RD_CAP,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_RD_SUM,
		ST_RD_FIN,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/multichannel_mix_peak_normalize_unit.sv -----
// Top level of the multichannel mix store with peak normalization.
// Depends on mpn_pkg and mpn_div; holds the accumulator store memory.
`timescale 1ns / 1ps

// Usage
//   cmd channel (cmd_valid/cmd_stall/cmd_data): one command beat, clear, accumulate,
//   finalize or read. rsp channel (rsp_valid/rsp_stall/rsp_data): one result beat per
//   command. cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): master_channels at
//   index 0, block_frames at index 1; write only while the block is idle.
//   One command is worked at a time; cmd_stall is high until its result sits in the
//   output register. Work per command, paced by the single store port:
//     clear      every store entry in turn (one store entry per cycle)
//     accumulate a read and a write back per channel touched
//     finalize   a scan of frames * channels store entries, plus the divider when the
//                peak exceeds 1.0
//     read       store read, two partial products, sum, round
//     out of range or no channels: straight to the result
//   After reset the store is zeroed by a pass over all MAX_FRAMES * 2^ceil(log2(MAX_CHANNELS))
//   entries; the cmd channel stalls meanwhile, configuration writes are taken. A result
//   waits in the output register while rsp_stall is high, and the next command is taken
//   meanwhile.
module multichannel_mix_peak_normalize_unit #(
	parameter int MAX_FRAMES   = mpn_pkg::MAX_FRAMES_DEF,
	parameter int MAX_CHANNELS = mpn_pkg::MAX_CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  mpn_pkg::cmd_beat_t                cmd_data,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output mpn_pkg::rsp_beat_t                rsp_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mpn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mpn_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mpn_pkg::*;

	localparam int FW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int AW     = FW + CW;
	localparam int DEPTH  = MAX_FRAMES * (1 << CW);
	localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
	localparam int NFR_W  = $clog2(MAX_FRAMES + 1);
	localparam int MUL_W  = 40;
	localparam int SUM_W  = 60;

	state_t state_q, state_d;

	logic [3:0]  master_channels_q;
	logic [8:0]  block_frames_q;
	logic [NCH_W-1:0] nch;
	logic [NFR_W-1:0] nfr;

	cmd_beat_t item_q;
	logic      clr_reply_q;
	logic [AW-1:0] sweep_q;
	logic [CW-1:0] chan_q;
	logic [FW-1:0] scan_f_q;
	logic [CW-1:0] scan_c_q;
	logic          scan_last;
	logic          scan_rdv_s1;
	logic [ACC_W-1:0] peak_q;
	logic [SCALE_W-1:0] scale_q;
	logic          active_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] prod_mul;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [MUL_W-1:0]  plo_q, phi_q, mul_p;
	logic signed [20:0]       mul_a;
	logic signed [SUM_W-1:0]  psum_q, rnd;
	logic signed [15:0]       res_sample_q;
	status_t                  res_status_q;

	logic            accept;
	logic            frame_bad, chan_bad;
	logic            last_chan;
	logic            out_free;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr, mem_raddr, item_addr;
	logic [ACC_W-1:0] mem_wdata, mem_rdata;
	logic [ACC_W:0]  acc_sum;
	logic [ACC_W-1:0] acc_sat;
	logic [ACC_W-1:0] mag;
	logic            div_start, div_done;
	logic [SCALE_W-1:0] div_quo;

	logic [ACC_W-1:0] store_mem [DEPTH];

	rsp_beat_t rsp_q;
	logic      rsp_valid_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_channels_q <= MASTER_CHANNELS_RST;
			block_frames_q    <= BLOCK_FRAMES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MASTER_CHANNELS: master_channels_q <= cfg_data[3:0];
				REG_BLOCK_FRAMES:    block_frames_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign nch = (32'(master_channels_q) < MAX_CHANNELS) ? NCH_W'(master_channels_q)
	                                                      : NCH_W'(MAX_CHANNELS);
	assign nfr = (32'(block_frames_q) < MAX_FRAMES) ? NFR_W'(block_frames_q)
	                                                 : NFR_W'(MAX_FRAMES);

	// command decode
	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign frame_bad = 32'(cmd_data.frame_index) >= 32'(nfr);
	assign chan_bad  = 32'(cmd_data.channel) >= 32'(nch);
	assign prod_mul  = $signed({{17{cmd_data.sample[15]}}, cmd_data.sample})
	                 * $signed({17'b0, cmd_data.gain});

	assign item_addr = {FW'(item_q.frame_index), CW'(item_q.channel)};
	assign last_chan = (32'(chan_q) + 32'd1) >= 32'(nch);
	assign scan_last = (32'(scan_c_q) + 32'd1 >= 32'(nch))
	                && (32'(scan_f_q) + 32'd1 >= 32'(nfr));
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// saturating accumulate
	assign acc_sum = {mem_rdata[ACC_W-1], mem_rdata}
	               + (ACC_W+1)'($signed(prod_q));
	always_comb begin
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end
	end

	assign mag = mem_rdata[ACC_W-1] ? ACC_W'(-{1'b1, mem_rdata}) : mem_rdata;

	// next state and store port control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = '0;
		mem_raddr = item_addr;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (cmd_data.cmd == CMD_CLEAR) begin
						state_d = ST_CLEAR;
					end else if (nch == '0) begin
						state_d = ST_DONE;
					end else if (cmd_data.cmd == CMD_ACC) begin
						state_d = (frame_bad || (!cmd_data.mono_source && chan_bad))
						        ? ST_DONE : ST_ACC_RD;
					end else if (cmd_data.cmd == CMD_FIN) begin
						state_d = (nfr == '0) ? ST_SCAN_DEC : ST_SCAN;
					end else begin
						state_d = (frame_bad || chan_bad) ? ST_DONE : ST_RD_MEM;
					end
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (sweep_q == AW'(DEPTH - 1)) begin
					state_d = clr_reply_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_ACC_RD: begin
				mem_raddr = {FW'(item_q.frame_index), chan_q};
				state_d   = ST_ACC_WR;
			end
			ST_ACC_WR: begin
				mem_we    = 1'b1;
				mem_waddr = {FW'(item_q.frame_index), chan_q};
				mem_wdata = acc_sat;
				state_d   = (item_q.mono_source && !last_chan) ? ST_ACC_RD : ST_DONE;
			end
			ST_SCAN: begin
				mem_raddr = {scan_f_q, scan_c_q};
				if (scan_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: state_d = ST_SCAN_DEC;
			ST_SCAN_DEC: begin
				if (peak_q > ONE_Q27) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_RD_MEM: state_d = ST_RD_CAP;
			ST_RD_CAP: state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_RD_SUM;
			ST_RD_SUM: state_d = ST_RD_FIN;
			ST_RD_FIN: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// store memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata <= store_mem[mem_raddr];
	end

	mpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (peak_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// read product: two partial products on one multiplier
	assign mul_a = (state_q == ST_MUL_LO) ? $signed({1'b0, acc_q[19:0]})
	                                      : $signed(acc_q[ACC_W-1:20]);
	assign mul_p = $signed({{19{mul_a[20]}}, mul_a}) * $signed({22'b0, scale_q});
	assign rnd   = (psum_q + SUM_W'(64'sd268435456)) >>> 29;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			clr_reply_q <= 1'b0;
			scale_q     <= SCALE_UNITY;
			active_q    <= 1'b0;
			scan_rdv_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			scan_rdv_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sweep_q     <= '0;
						clr_reply_q <= 1'b1;
						if (cmd_data.cmd == CMD_FIN && nch == '0) begin
							scale_q  <= SCALE_UNITY;
							active_q <= 1'b0;
						end
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(DEPTH - 1)) begin
						scale_q  <= SCALE_UNITY;
						active_q <= 1'b0;
					end
				end
				ST_SCAN_DEC: begin
					if (!(peak_q > ONE_Q27)) begin
						scale_q  <= SCALE_UNITY;
						active_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						scale_q  <= div_quo;
						active_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (scan_rdv_s1 && mag > peak_q) begin
			peak_q <= mag;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_q       <= cmd_data;
					prod_q       <= prod_mul;
					chan_q       <= cmd_data.mono_source ? '0 : CW'(cmd_data.channel);
					scan_f_q     <= '0;
					scan_c_q     <= '0;
					peak_q       <= '0;
					res_sample_q <= '0;
					priority if (cmd_data.cmd == CMD_CLEAR) begin
						res_status_q <= STAT_OK;
					end else if (nch == '0) begin
						res_status_q <= STAT_NOCH;
					end else if (cmd_data.cmd == CMD_ACC) begin
						res_status_q <= (frame_bad || (!cmd_data.mono_source && chan_bad))
						              ? STAT_RANGE : STAT_OK;
					end else if (cmd_data.cmd == CMD_FIN) begin
						res_status_q <= STAT_OK;
					end else begin
						res_status_q <= (frame_bad || chan_bad) ? STAT_RANGE : STAT_OK;
					end
				end
			end
			ST_ACC_WR: chan_q <= chan_q + 1'b1;
			ST_SCAN: begin
				if (32'(scan_c_q) + 32'd1 >= 32'(nch)) begin
					scan_c_q <= '0;
					scan_f_q <= scan_f_q + 1'b1;
				end else begin
					scan_c_q <= scan_c_q + 1'b1;
				end
			end
			ST_RD_CAP: acc_q <= $signed(mem_rdata);
			ST_MUL_LO: plo_q <= mul_p;
			ST_MUL_HI: phi_q <= mul_p;
			ST_RD_SUM: psum_q <= ($signed(SUM_W'(phi_q)) <<< 20) + SUM_W'(plo_q);
			ST_RD_FIN: begin
				priority if (rnd > SUM_W'(64'sd32767)) begin
					res_sample_q <= 16'sh7fff;
				end else if (rnd < -SUM_W'(64'sd32768)) begin
					res_sample_q <= 16'sh8000;
				end else begin
					res_sample_q <= rnd[15:0];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_q.sample_out <= res_sample_q;
					rsp_q.normalized <= active_q;
					rsp_q.status     <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ----- rtl/mpn_div.sv -----
// Iterative reciprocal divider: quotient = floor(2^44 / peak), one bit per cycle.
// Valid for peak above 2^27, so the quotient fits in QUO_BITS bits.
// Depends on mpn_pkg.
`timescale 1ns / 1ps

module mpn_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mpn_pkg::ACC_W-1:0]    divisor,
	output logic                         done,
	output logic [mpn_pkg::SCALE_W-1:0]  quotient
);
	import mpn_pkg::*;

	localparam int CNT_W = $clog2(QUO_BITS + 1);

	logic [ACC_W-1:0]    rem_q;
	logic [ACC_W-1:0]    div_q;
	logic [QUO_BITS-1:0] quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [ACC_W:0]      trial;
	logic                fits;

	assign trial = {rem_q, 1'b0};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ONE_Q27;
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? ACC_W'(trial - {1'b0, div_q}) : ACC_W'(trial);
			quo_q <= {quo_q[QUO_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = SCALE_W'(quo_q);

endmodule
